/* hdl/tctk_pkg.sv */
// shared types and constants for the thread count top-k block
package tctk_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned BOARD_W = 6;
  localparam int unsigned RANK_W  = 7;

  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_MASK   = 2'd2;

  // one top-list entry
  typedef struct packed {
    logic [ID_W-1:0]    tid;
    logic [31:0]        cnt;
    logic [STAMP_W-1:0] last;
    logic [BOARD_W-1:0] board;
  } entry_t;

  // command broadcast along the cell row
  typedef struct packed {
    logic   ins;     // insert candidate this cycle
    logic   rmv;     // remove matching tid this cycle
    logic   clr;     // clear all cells
    logic   shl;     // shift left by one (read-out)
    entry_t cand;
  } cell_cmd_t;

  // one table entry
  typedef struct packed {
    logic [ID_W-1:0]    tid;
    logic [31:0]        cnt;
    logic [STAMP_W-1:0] last;
  } tab_t;

endpackage

/* hdl/tctk_ram.sv */
// generic simple dual port ram (one write port, one read port) with registered read
module tctk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/tctk_cell.sv */
// one sorted list cell: holds an entry, compares, shifts with neighbors
module tctk_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tctk_pkg::cell_cmd_t  cmd,
  input  logic                 en,        // cell index below limit
  input  tctk_pkg::entry_t     left_ent,
  input  logic                 left_val,
  input  logic                 left_beats,
  input  logic                 left_gone,
  input  tctk_pkg::entry_t     right_ent,
  input  logic                 right_val,
  output tctk_pkg::entry_t     ent,
  output logic                 val,
  output logic                 beats,     // candidate beats this or earlier
  output logic                 gone       // matching entry here or earlier
);
  import tctk_pkg::*;

  entry_t ent_r, ent_nxt;
  logic   val_r, val_nxt;
  logic   here_beats, here_match;

  // compare the candidate against the held entry
  always_comb begin
    here_beats = !val_r ||
                 (cmd.cand.cnt > ent_r.cnt) ||
                 ((cmd.cand.cnt == ent_r.cnt) && (cmd.cand.last > ent_r.last));
    here_match = val_r && (ent_r.tid == cmd.cand.tid);
  end

  assign beats = left_beats || here_beats;
  assign gone  = left_gone || here_match;
  assign ent   = ent_r;
  assign val   = val_r;

  // next entry: clear empties, insert shifts right, remove and read-out shift left
  always_comb begin
    ent_nxt = ent_r;
    val_nxt = val_r;
    if (cmd.clr) begin
      val_nxt = 1'b0;
    end else if (cmd.shl || (cmd.rmv && gone)) begin
      ent_nxt = right_ent;
      val_nxt = right_val;
    end else if (cmd.ins && beats) begin
      if (left_beats) begin
        ent_nxt = left_ent;
        val_nxt = left_val;
      end else begin
        ent_nxt = cmd.cand;
        val_nxt = 1'b1;
      end
    end
    // cells past the limit drop their entry when the list is next updated
    if (!en && (cmd.rmv || cmd.ins)) begin
      val_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
    end else begin
      val_r <= val_nxt;
    end
    ent_r <= ent_nxt;
  end

endmodule

/* hdl/tctk_list.sv */
// row of sorted list cells
module tctk_list #(
  parameter int unsigned TOP_MAX = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tctk_pkg::cell_cmd_t     cmd,
  input  logic [TOP_MAX-1:0]      en,
  output tctk_pkg::entry_t        head_ent,
  output logic                    head_val,
  output logic                    second_val, // entry behind the head
  output logic                    admit_ok    // candidate would be kept
);
  import tctk_pkg::*;

  entry_t         ents [TOP_MAX+1];
  logic           vals [TOP_MAX+1];
  logic           bts  [TOP_MAX];
  logic           gns  [TOP_MAX];
  logic [TOP_MAX:0] en_x;

  assign ents[TOP_MAX] = '0;
  assign vals[TOP_MAX] = 1'b0;
  assign en_x = {1'b0, en};

  // chain of cells, left neighbor is lower index
  for (genvar i = 0; i < TOP_MAX; i++) begin : g_cell
    tctk_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .en         (en[i]),
      .left_ent   ((i == 0) ? '0 : ents[(i == 0) ? 0 : i-1]),
      .left_val   ((i == 0) ? 1'b0 : vals[(i == 0) ? 0 : i-1]),
      .left_beats ((i == 0) ? 1'b0 : bts[(i == 0) ? 0 : i-1]),
      .left_gone  ((i == 0) ? 1'b0 : gns[(i == 0) ? 0 : i-1]),
      .right_ent  (ents[i+1]),
      .right_val  (vals[i+1] && en_x[i+1]),
      .ent        (ents[i]),
      .val        (vals[i]),
      .beats      (bts[i]),
      .gone       (gns[i])
    );
  end

  // candidate kept if the last enabled cell is free or holds a lower count
  always_comb begin
    admit_ok = 1'b0;
    for (int i = 0; i < TOP_MAX; i++) begin
      if (en_x[i] && !en_x[i+1]) begin
        admit_ok = !vals[i] || (cmd.cand.cnt > ents[i].cnt);
      end
    end
  end

  assign head_ent   = ents[0];
  assign head_val   = vals[0];
  assign second_val = vals[1];

endmodule

/* hdl/thread_count_top_k_top.sv */
// top level of the thread count top-k block
//
// Input channel in_*: one transaction is a post record (in_req_type 0) or a
// read-out request (in_req_type 1). A counted post looks its thread up in
// the thread table ram, reading then comparing each used slot in turn; the
// block stays busy through the scan and the table update. A thread opener
// adds a remove step and an insert step along the row of cells. A skipped
// post leaves the block idle. Posts give no result.
// Output channel out_*: a read-out gives one transaction per listed thread,
// hottest first, or one zero entry when the list is empty, starting the cycle
// after the request and advancing to the next entry after each transaction
// accepted while out_stall is low; is_last marks the final one. The list
// then clears along with the table count and flags.
// Reset (rst_n low, synchronous) empties list and table and restores the
// configuration registers. A stalled result holds; no new request is taken
// until the read-out is complete.
module thread_count_top_k_top #(
  parameter int unsigned THREAD_SLOTS = 1024,
  parameter int unsigned TOP_MAX      = 64,
  parameter int unsigned BOARD_COUNT  = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_req_type,
  input  logic [31:0]                in_post_stamp,
  input  logic [tctk_pkg::BOARD_W-1:0] in_board_num,
  input  logic                       in_is_deleted,
  input  logic [31:0]                in_post_num,
  input  logic [31:0]                in_thread_offset,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tctk_pkg::RANK_W-1:0] out_rank,
  output logic [31:0]                out_thread_num,
  output logic [tctk_pkg::BOARD_W-1:0] out_thread_board,
  output logic [31:0]                out_reply_total,
  output logic [31:0]                out_newest_stamp,
  output logic                       out_table_overflow,
  output logic                       out_is_last
);
  import tctk_pkg::*;

  localparam int unsigned AW = $clog2(THREAD_SLOTS);
  localparam int unsigned UW = $clog2(THREAD_SLOTS + 1);
  localparam int unsigned LW = $clog2(TOP_MAX + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CHK  = 7'b0000100,
    S_WR   = 7'b0001000,
    S_RMV  = 7'b0010000,
    S_INS  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t         st_r, st_nxt;
  logic [31:0]    win_r;
  logic [6:0]     lim_r;
  logic [31:0]    mask_r;
  logic           stop_r, stop_nxt;
  logic           ovf_r, ovf_nxt;
  logic [UW-1:0]  used_r, used_nxt;
  logic [UW-1:0]  idx_r, idx_nxt;
  logic [LW-1:0]  cnt_out_r, cnt_out_nxt;
  logic [LW-1:0]  lim_eff;
  logic [31:0]    tid_r, tid_nxt;
  logic [31:0]    stamp_r, stamp_nxt;
  logic [BOARD_W-1:0] board_r, board_nxt;
  logic           opener_r, opener_nxt;
  tab_t           hit_r, hit_nxt;
  logic           in_acc, out_acc;
  logic           eligible;

  // ram signals
  logic           t_we;
  logic [AW-1:0]  t_waddr, t_raddr;
  tab_t           t_wdata, t_rdata;

  // list signals
  cell_cmd_t          cmd;
  logic [TOP_MAX-1:0] en;
  entry_t             head_ent;
  logic               head_val, second_val, admit_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      lim_r  <= 7'd10;
      mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW: win_r  <= cfg_data;
        CFG_LIMIT:  lim_r  <= cfg_data[6:0];
        CFG_MASK:   mask_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // effective limit, clamped to 1..TOP_MAX
  always_comb begin
    if (lim_r == 7'd0) begin
      lim_eff = LW'(1);
    end else if (32'(lim_r) > 32'(TOP_MAX)) begin
      lim_eff = LW'(TOP_MAX);
    end else begin
      lim_eff = LW'(lim_r);
    end
    for (int i = 0; i < TOP_MAX; i++) begin
      en[i] = (32'(i) < 32'(lim_eff));
    end
  end

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = (st_r != S_IDLE);

  // post eligibility
  always_comb begin
    eligible = (in_board_num >= BOARD_W'(1)) &&
               (32'(in_board_num) <= 32'(BOARD_COUNT)) &&
               mask_r[5'(in_board_num - BOARD_W'(1))] && !in_is_deleted;
  end

  // thread table
  tctk_ram #(.WIDTH($bits(tab_t)), .DEPTH(THREAD_SLOTS)) u_tab (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign t_raddr = idx_r[AW-1:0];

  // sequencer
  always_comb begin
    st_nxt      = st_r;
    stop_nxt    = stop_r;
    ovf_nxt     = ovf_r;
    used_nxt    = used_r;
    idx_nxt     = idx_r;
    cnt_out_nxt = cnt_out_r;
    tid_nxt     = tid_r;
    stamp_nxt   = stamp_r;
    board_nxt   = board_r;
    opener_nxt  = opener_r;
    hit_nxt     = hit_r;
    t_we        = 1'b0;
    t_waddr     = idx_r[AW-1:0];
    t_wdata     = hit_r;
    cmd         = '0;
    cmd.cand    = '{tid: tid_r, cnt: hit_r.cnt, last: hit_r.last, board: board_r};
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type) begin
            cnt_out_nxt = LW'(1);
            st_nxt      = S_OUT;
          end else if (!stop_r && in_post_stamp != 32'd0) begin
            if (in_post_stamp <= win_r) begin
              stop_nxt = 1'b1;
            end else if (eligible) begin
              tid_nxt    = in_post_num - in_thread_offset;
              stamp_nxt  = in_post_stamp;
              board_nxt  = in_board_num;
              opener_nxt = (in_thread_offset == 32'd0);
              idx_nxt    = '0;
              st_nxt     = S_RD;
            end
          end
        end
      end
      S_RD: begin
        // ram read address idx_r issued this cycle
        if (idx_r >= used_r) begin
          st_nxt = S_WR;
        end else begin
          st_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (t_rdata.tid == tid_r) begin
          hit_nxt.tid  = tid_r;
          hit_nxt.cnt  = (t_rdata.cnt == 32'hFFFF_FFFF) ? t_rdata.cnt :
                         t_rdata.cnt + 32'd1;
          hit_nxt.last = (stamp_r > t_rdata.last) ? stamp_r : t_rdata.last;
          t_we    = 1'b1;
          t_wdata = hit_nxt;
          st_nxt  = opener_r ? S_RMV : S_IDLE;
        end else begin
          idx_nxt = idx_r + UW'(1);
          st_nxt  = S_RD;
        end
      end
      S_WR: begin
        // new thread
        if (used_r < UW'(THREAD_SLOTS)) begin
          hit_nxt  = '{tid: tid_r, cnt: 32'd1, last: stamp_r};
          t_we     = 1'b1;
          t_wdata  = hit_nxt;
          used_nxt = used_r + UW'(1);
          st_nxt   = opener_r ? S_RMV : S_IDLE;
        end else begin
          ovf_nxt = 1'b1;
          st_nxt  = S_IDLE;
        end
      end
      S_RMV: begin
        cmd.rmv = 1'b1;
        st_nxt  = S_INS;
      end
      S_INS: begin
        if (admit_ok) begin
          cmd.ins = 1'b1;
        end
        st_nxt = S_IDLE;
      end
      S_OUT: begin
        if (out_acc) begin
          cmd.shl     = 1'b1;
          cnt_out_nxt = cnt_out_r + LW'(1);
          if (out_is_last) begin
            cmd.clr  = 1'b1;
            used_nxt = '0;
            stop_nxt = 1'b0;
            ovf_nxt  = 1'b0;
            st_nxt   = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  tctk_list #(.TOP_MAX(TOP_MAX)) u_list (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .en         (en),
    .head_ent   (head_ent),
    .head_val   (head_val),
    .second_val (second_val),
    .admit_ok   (admit_ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      stop_r    <= 1'b0;
      ovf_r     <= 1'b0;
      used_r    <= '0;
    end else begin
      st_r      <= st_nxt;
      stop_r    <= stop_nxt;
      ovf_r     <= ovf_nxt;
      used_r    <= used_nxt;
    end
    idx_r     <= idx_nxt;
    cnt_out_r <= cnt_out_nxt;
    tid_r     <= tid_nxt;
    stamp_r   <= stamp_nxt;
    board_r   <= board_nxt;
    opener_r  <= opener_nxt;
    hit_r     <= hit_nxt;
  end

  // read-out drives the head cell, the row shifts left each transaction
  logic next_val;
  assign next_val = (32'(cnt_out_r) < 32'(lim_eff));
  assign out_valid          = (st_r == S_OUT);
  assign out_rank           = head_val ? RANK_W'(cnt_out_r) : '0;
  assign out_thread_num     = head_val ? head_ent.tid : '0;
  assign out_thread_board   = head_val ? head_ent.board : '0;
  assign out_reply_total    = head_val ? head_ent.cnt : '0;
  assign out_newest_stamp   = head_val ? head_ent.last : '0;
  assign out_table_overflow = ovf_r;
  assign out_is_last        = !head_val || !next_val || !second_val;

`ifndef SYNTHESIS
  // no new request while busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("accepted while busy");
  // output only in read-out
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (st_r == S_OUT)) else $error("stray output");
  // used count never exceeds slots
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(THREAD_SLOTS)) else $error("table count overrun");
  // last read-out clears flags
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_is_last) |=> (!stop_r && !ovf_r)) else $error("clear missed");
`endif

endmodule

/* test/tb_thread_count_top_k_top.sv */
// self-checking testbench for the thread count top-k block
module tb_thread_count_top_k_top;
  import tctk_pkg::*;

  localparam int SLOTS      = 1024;
  localparam int TOPN       = 64;
  localparam int BOARDS     = 32;
  localparam int POST_DRAIN = 2 * SLOTS + 16;  // a post may scan every used table slot

  localparam bit REQ_POST = 1'b0;
  localparam bit REQ_READ = 1'b1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = CFG_WINDOW;
  logic [31:0]         cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_req_type = REQ_POST;
  logic [31:0]         in_post_stamp = '0;
  logic [BOARD_W-1:0]  in_board_num = '0;
  logic                in_is_deleted = 1'b0;
  logic [31:0]         in_post_num = '0;
  logic [31:0]         in_thread_offset = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [RANK_W-1:0]   out_rank;
  logic [31:0]         out_thread_num;
  logic [BOARD_W-1:0]  out_thread_board;
  logic [31:0]         out_reply_total;
  logic [31:0]         out_newest_stamp;
  logic                out_table_overflow;
  logic                out_is_last;

  thread_count_top_k_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_post_stamp(in_post_stamp), .in_board_num(in_board_num),
    .in_is_deleted(in_is_deleted), .in_post_num(in_post_num),
    .in_thread_offset(in_thread_offset),
    .out_valid(out_valid), .out_stall(out_stall), .out_rank(out_rank),
    .out_thread_num(out_thread_num), .out_thread_board(out_thread_board),
    .out_reply_total(out_reply_total), .out_newest_stamp(out_newest_stamp),
    .out_table_overflow(out_table_overflow), .out_is_last(out_is_last)
  );

  always #2 clk = ~clk;

  // one ranked thread as read out
  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [31:0]        tnum;
    logic [BOARD_W-1:0] board;
    logic [31:0]        total;
    logic [31:0]        stamp;
    logic               ovf;
    logic               last;
  } hot_t;

  hot_t hot_q[$];
  int   errors = 0;
  int   posts_sent = 0;
  int   readouts_sent = 0;
  int   entries_seen = 0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;

  // predictor state
  logic [31:0] win_r, mask_r;
  logic [6:0]  lim_r;
  logic [31:0] tab_tid[SLOTS];
  logic [31:0] tab_cnt[SLOTS];
  logic [31:0] tab_last[SLOTS];
  int          tab_used;
  entry_t      top_list[TOPN];
  int          top_fill;
  bit          stopped, ovf_seen;

  function automatic int eff_lim();
    int lim;
    lim = lim_r;
    if (lim < 1) lim = 1;
    if (lim > TOPN) lim = TOPN;
    return lim;
  endfunction

  function automatic void clear_counts();
    tab_used = 0;
    top_fill = 0;
    stopped  = 1'b0;
    ovf_seen = 1'b0;
  endfunction

  // place a thread in the ranked list, count desc then stamp desc
  function automatic void rank_thread(entry_t e);
    int lim, i, pos;
    lim = eff_lim();
    if (top_fill > lim) top_fill = lim;
    for (i = 0; i < top_fill; i++) begin
      if (top_list[i].tid == e.tid) begin
        for (int j = i; j + 1 < top_fill; j++) top_list[j] = top_list[j+1];
        top_fill--;
        break;
      end
    end
    if (top_fill >= lim && !(e.cnt > top_list[lim-1].cnt)) return;
    pos = top_fill;
    for (i = 0; i < top_fill; i++) begin
      if (e.cnt > top_list[i].cnt ||
          (e.cnt == top_list[i].cnt && e.last > top_list[i].last)) begin
        pos = i;
        break;
      end
    end
    if (top_fill < lim) begin
      for (i = top_fill; i > pos; i--) top_list[i] = top_list[i-1];
      top_fill++;
    end else begin
      for (i = lim - 1; i > pos; i--) top_list[i] = top_list[i-1];
    end
    top_list[pos] = e;
  endfunction

  // count one post against its thread
  function automatic void count_post(logic [31:0] st, logic [5:0] bd, bit dl,
                                     logic [31:0] pn, logic [31:0] po);
    logic [31:0] tid;
    int slot;
    entry_t e;
    if (stopped) return;
    if (st != 0 && st <= win_r) begin
      stopped = 1'b1;
      return;
    end
    if (st == 0) return;
    if (bd < 1 || bd > BOARDS) return;
    if (!mask_r[bd-1] || dl) return;
    tid = pn - po;
    slot = tab_used;
    for (int i = 0; i < tab_used; i++) begin
      if (tab_tid[i] == tid) begin
        slot = i;
        break;
      end
    end
    if (slot < tab_used) begin
      if (tab_cnt[slot] != 32'hFFFF_FFFF) tab_cnt[slot]++;
      if (st > tab_last[slot]) tab_last[slot] = st;
    end else if (tab_used < SLOTS) begin
      tab_used++;
      tab_tid[slot]  = tid;
      tab_cnt[slot]  = 1;
      tab_last[slot] = st;
    end else begin
      ovf_seen = 1'b1;
      return;
    end
    if (po == 0) begin
      e.tid = tid; e.cnt = tab_cnt[slot]; e.last = tab_last[slot]; e.board = bd;
      rank_thread(e);
    end
  endfunction

  // queue the ranked list for a read-out and clear
  function automatic void read_out();
    int n;
    hot_t h;
    n = (top_fill > eff_lim()) ? eff_lim() : top_fill;
    if (n == 0) begin
      h = '0;
      h.ovf = ovf_seen;
      h.last = 1'b1;
      hot_q.push_back(h);
    end
    for (int k = 0; k < n; k++) begin
      h.rank  = RANK_W'(k + 1);
      h.tnum  = top_list[k].tid;
      h.board = top_list[k].board;
      h.total = top_list[k].cnt;
      h.stamp = top_list[k].last;
      h.ovf   = ovf_seen;
      h.last  = (k + 1 == n);
      hot_q.push_back(h);
    end
    clear_counts();
  endfunction

  // drive one transaction and wait for its acceptance
  task automatic send(bit rt, logic [31:0] st, logic [5:0] bd, bit dl,
                      logic [31:0] pn, logic [31:0] po,
                      bit typed = 1'b0, hot_t tv = '0);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_post_stamp <= st;
    in_board_num <= bd;
    in_is_deleted <= dl;
    in_post_num <= pn;
    in_thread_offset <= po;
    do @(posedge clk); while (in_stall);
    if (rt == REQ_POST) begin
      count_post(st, bd, dl, pn, po);
      posts_sent++;
    end else begin
      read_out();
      readouts_sent++;
      if (typed) hot_q[hot_q.size()-1] = tv;
    end
  endtask

  task automatic in_rest();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // write all three registers once the block is idle
  task automatic write_regs(logic [31:0] win, logic [31:0] lim, logic [31:0] msk);
    in_rest();
    while (hot_q.size() != 0) @(posedge clk);
    repeat (POST_DRAIN) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WINDOW; cfg_data <= win;
    @(posedge clk);
    cfg_index <= CFG_LIMIT; cfg_data <= lim;
    @(posedge clk);
    cfg_index <= CFG_MASK; cfg_data <= msk;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_r = win;
    lim_r = lim[6:0];
    mask_r = msk;
  endtask

  // result channel stall, with one long hold on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void cmp_field(string name, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp, got);
      errors++;
    end
  endfunction

  // compare each result transaction with the oldest expectation
  hot_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      entries_seen++;
      if (hot_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual thread %h rank %0d",
                 $time, out_thread_num, out_rank);
        errors++;
      end else begin
        want = hot_q.pop_front();
        cmp_field("rank", want.rank, out_rank);
        cmp_field("thread_num", want.tnum, out_thread_num);
        cmp_field("thread_board", want.board, out_thread_board);
        cmp_field("reply_total", want.total, out_reply_total);
        cmp_field("newest_stamp", want.stamp, out_newest_stamp);
        cmp_field("table_overflow", want.ovf, out_table_overflow);
        cmp_field("is_last", want.last, out_is_last);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("** thread_count_top_k_top: FAILED **");
    $finish;
  end

  // directed stimulus rows
  typedef struct {
    bit          rt;
    logic [31:0] st;
    logic [5:0]  bd;
    bit          dl;
    logic [31:0] pn;
    logic [31:0] po;
    bit          typed;
  } row_t;

  localparam hot_t EMPTY_READ = '{rank: 0, tnum: 0, board: 0, total: 0, stamp: 0,
                                  ovf: 0, last: 1};

  row_t rows[] = '{
    '{REQ_POST, 32'd0,          6'd1,  0, 32'd7,          32'd0,          0}, // absent
    '{REQ_POST, 32'd900,        6'd0,  0, 32'd7,          32'd0,          0}, // board 0
    '{REQ_POST, 32'd900,        6'd33, 0, 32'd7,          32'd0,          0},
    '{REQ_POST, 32'd900,        6'd63, 0, 32'd7,          32'd0,          0},
    '{REQ_POST, 32'd900,        6'd2,  1, 32'd7,          32'd0,          0}, // deleted
    '{REQ_POST, 32'd500,        6'd1,  0, 32'd1005,       32'd5,          0}, // reply
    '{REQ_POST, 32'd400,        6'd1,  0, 32'd1000,       32'd0,          0}, // opener
    '{REQ_POST, 32'd450,        6'd32, 0, 32'd2000,       32'd0,          0},
    '{REQ_POST, 32'd450,        6'd3,  0, 32'd3000,       32'd0,          0}, // tie
    '{REQ_POST, 32'd300,        6'd4,  0, 32'd4000,       32'd0,          0}, // rejected
    '{REQ_POST, 32'd460,        6'd5,  0, 32'd2001,       32'd1,          0},
    '{REQ_POST, 32'd440,        6'd32, 0, 32'd2000,       32'd0,          0}, // re-listed
    '{REQ_POST, 32'hFFFF_FFFF,  6'd1,  0, 32'd0,          32'd0,          0},
    '{REQ_POST, 32'd101,        6'd1,  0, 32'd0,          32'hFFFF_FFFF,  0}, // wraps
    '{REQ_POST, 32'd150,        6'd1,  0, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  0},
    '{REQ_POST, 32'd100,        6'd1,  0, 32'd1000,       32'd0,          0}, // stop
    '{REQ_POST, 32'd900,        6'd1,  0, 32'd1000,       32'd0,          0}, // ignored
    '{REQ_READ, 32'd0,          6'd0,  0, 32'd0,          32'd0,          0},
    '{REQ_READ, 32'hFFFF_FFFF,  6'h3F, 1, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1}
  };

  initial begin
    logic [31:0] pool[6];
    logic [31:0] st, tid, off, w, l, m;
    int npost, kind, pass_no, rand_items;

    win_r = 0; lim_r = 10; mask_r = 0;
    clear_counts();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // read-out straight after reset gives the empty entry
    send(REQ_READ, 0, 0, 0, 0, 0, 1'b1, EMPTY_READ);

    // directed table, list of three
    write_regs(32'd100, 32'd3, 32'hFFFF_FFFF);
    foreach (rows[i])
      send(rows[i].rt, rows[i].st, rows[i].bd, rows[i].dl, rows[i].pn, rows[i].po,
           rows[i].typed, EMPTY_READ);

    // limit above the maximum clamps, window at top stops on any stamp
    write_regs(32'hFFFF_FFFF, 32'd127, 32'h0000_0001);
    send(REQ_POST, 32'hFFFF_FFFF, 6'd1, 0, 32'd9, 32'd0);
    send(REQ_READ, 0, 0, 0, 0, 0, 1'b1, EMPTY_READ);
    write_regs(32'd0, 32'd0, 32'hFFFF_FFFF);
    send(REQ_POST, 32'd10, 6'd1, 0, 32'd9, 32'd0);
    send(REQ_POST, 32'd11, 6'd2, 0, 32'd8, 32'd0);
    send(REQ_READ, 0, 0, 0, 0, 0);

    // random passes: mostly well-formed post streams ending in a read-out
    rand_items = 0;
    pass_no = 0;
    while (rand_items < 475) begin
      if (pass_no % 5 == 0) begin
        case ($urandom_range(0, 5))
          0: w = 32'd0;
          1: w = $urandom;
          default: w = $urandom_range(0, 1000);
        endcase
        case ($urandom_range(0, 7))
          0: l = 32'd64;
          1: l = $urandom_range(65, 127);
          2: l = 32'd0;
          default: l = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 5))
          0: m = $urandom;
          1: m = 32'd0;
          default: m = 32'hFFFF_FFFF;
        endcase
        write_regs(w, l, m);
      end
      foreach (pool[i]) pool[i] = $urandom;
      st = (win_r > 32'hFFF0_0000) ? 32'hFFFF_FFFF : win_r + $urandom_range(200, 100000);
      npost = $urandom_range(3, 30);
      for (int k = 0; k < npost; k++) begin
        kind = $urandom_range(0, 19);
        st = st - $urandom_range(0, 3);
        if (rand_items > 420) calm = 1'b1;
        case (kind)
          0: send(REQ_POST, $urandom, 6'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)), $urandom, $urandom);
          1: send(REQ_POST, 32'd0, 6'($urandom_range(1, 32)), 0, $urandom, 32'd0);
          2: send(REQ_POST, st, 6'($urandom_range(1, 32)), 1, pool[0], 32'd0);
          3: send(REQ_POST, (win_r == 0) ? st : $urandom_range(1, win_r),
                  6'($urandom_range(1, 32)), 0, pool[1], 32'd0);
          default: begin
            tid = pool[$urandom_range(0, 5)];
            off = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 500);
            send(REQ_POST, st, 6'($urandom_range(1, 32)), 0, tid + off, off);
          end
        endcase
        rand_items++;
      end
      if (pass_no == 10) hold_req = 1'b1;  // long hold on the result side
      send(REQ_READ, $urandom, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
           $urandom, $urandom);
      rand_items++;
      pass_no++;
    end

    in_rest();
    while (hot_q.size() != 0) @(posedge clk);
    repeat (POST_DRAIN) @(posedge clk);
    $display("covered %0d posts and %0d read-outs, %0d ranked entries checked",
             posts_sent, readouts_sent, entries_seen);
    $display("included limit clamping, re-listing, ties and pass stops under stalls");
    if (errors == 0)
      $display("** thread_count_top_k_top: PASSED **");
    else
      $display("** thread_count_top_k_top: FAILED **");
    $finish;
  end

endmodule

/* files.f */
hdl/tctk_pkg.sv
hdl/tctk_ram.sv
hdl/tctk_cell.sv
hdl/tctk_list.sv
hdl/thread_count_top_k_top.sv
test/tb_thread_count_top_k_top.sv
